FILE: rtl/core/apt_pkg.sv
// shared types and constants for the aging peer table
package apt_pkg;

  localparam logic [1:0] OP_UPSERT = 2'd0;
  localparam logic [1:0] OP_LIST   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [2:0] STS_INSERTED  = 3'd0;
  localparam logic [2:0] STS_REFRESHED = 3'd1;
  localparam logic [2:0] STS_FULL      = 3'd2;
  localparam logic [2:0] STS_LOOPBACK  = 3'd3;
  localparam logic [2:0] STS_ENTRY     = 3'd4;
  localparam logic [2:0] STS_EMPTY     = 3'd5;
  localparam logic [2:0] STS_CLEARED   = 3'd6;

  localparam logic [15:0] TTL_RESET    = 16'd5000;
  localparam logic [7:0]  LOOPBACK_NET = 8'd127;
  localparam logic [6:0]  MAX_RESULTS  = 7'd64;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] peer_address;
    logic [63:0] peer_tag;
    logic [31:0] now_ms;
    logic [6:0]  max_count;
  } apt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_address;
    logic [63:0] found_tag;
    logic        last;
  } apt_out_t;

  typedef struct packed {
    logic [31:0] address;
    logic [63:0] tag;
    logic [31:0] seen_ms;
  } apt_entry_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } apt_state_t;

endpackage

FILE: rtl/core/aging_peer_table_unit.sv
// aging peer table: learning table of peers with ttl-based expiry and listing
//
//   channel   direction  handshake                  payload
//   in        input      in_valid / in_stall        apt_pkg::apt_in_t  in_item
//   out       output     out_valid / out_stall      apt_pkg::apt_out_t out_item
//   cfg       input      cfg_write_en               ttl_ms on cfg_write_data
//
// upsert and listing walk every slot through the entry ram's single read port,
// one slot a cycle while the output is not stalled
// loopback drops, clears and the unused opcode finish in idle without a scan
// reset is synchronous; live bits sit in flops and clear at once, no ram sweep
// a stalled output beat freezes the scan; one item is worked on at a time
module aging_peer_table_unit #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  apt_pkg::apt_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output apt_pkg::apt_out_t out_item,
  input  logic              cfg_write_en,
  input  logic [15:0]       cfg_write_data
);

  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int ENTRY_W = $bits(apt_pkg::apt_entry_t);

  // control state
  apt_pkg::apt_state_t state, state_next;
  logic [TABLE_ENTRIES-1:0] live, live_next;
  logic [15:0] ttl;
  logic out_valid_next;
  apt_pkg::apt_out_t out_item_next;

  // scan pipeline: rd_idx issues the ram read, ev_idx is the slot whose data is back
  logic [CNT_W-1:0] rd_idx, rd_idx_next;
  logic ev_valid, ev_valid_next;
  logic [IDX_W-1:0] ev_idx, ev_idx_next;

  // the item being worked on
  logic [1:0]  op, op_next;
  logic [31:0] item_addr, item_addr_next;
  logic [63:0] item_tag, item_tag_next;
  logic [31:0] item_now, item_now_next;
  logic [6:0]  maxc, maxc_next;

  // upsert search results
  logic matched, matched_next;
  logic free_found, free_found_next;
  logic [IDX_W-1:0] free_idx, free_idx_next;

  // listing: entry held back until we know whether it is the final one
  logic [6:0]  count, count_next;
  logic        pend_valid, pend_valid_next;
  logic [31:0] pend_addr, pend_addr_next;
  logic [63:0] pend_tag, pend_tag_next;

  // ram ports
  logic ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr;
  apt_pkg::apt_entry_t ram_wentry, ent;
  logic [ENTRY_W-1:0] ram_rdata;

  logic out_free, in_acc, scan_more, ev_live, expired;
  logic [31:0] age;

  function automatic apt_pkg::apt_out_t mk_beat(input logic [2:0] status,
                                                input logic [31:0] addr,
                                                input logic [63:0] tag,
                                                input logic last);
    apt_pkg::apt_out_t r;
    r.status        = status;
    r.found_address = addr;
    r.found_tag     = tag;
    r.last          = last;
    return r;
  endfunction

  // output register frees up when empty or taken this cycle
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !((state == apt_pkg::ST_IDLE) && out_free);
  assign in_acc    = in_valid && !in_stall;
  assign scan_more = rd_idx < CNT_W'(TABLE_ENTRIES);
  assign ram_re    = (state == apt_pkg::ST_SCAN) && out_free && scan_more;

  assign ent     = apt_pkg::apt_entry_t'(ram_rdata);
  assign ev_live = live[ev_idx];
  // modular age against the ttl register
  assign age     = item_now - ent.seen_ms;
  assign expired = age > {16'd0, ttl};

  apt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .re    (ram_re),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    live_next       = live;
    out_valid_next  = out_valid && out_stall;
    out_item_next   = out_item;
    rd_idx_next     = rd_idx;
    ev_valid_next   = ev_valid;
    ev_idx_next     = ev_idx;
    op_next         = op;
    item_addr_next  = item_addr;
    item_tag_next   = item_tag;
    item_now_next   = item_now;
    maxc_next       = maxc;
    matched_next    = matched;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    count_next      = count;
    pend_valid_next = pend_valid;
    pend_addr_next  = pend_addr;
    pend_tag_next   = pend_tag;
    ram_we          = 1'b0;
    ram_waddr       = ev_idx;
    ram_wentry      = {item_addr, item_tag, item_now};

    unique case (state)
      apt_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_next         = in_item.opcode;
          item_addr_next  = in_item.peer_address;
          item_tag_next   = in_item.peer_tag;
          item_now_next   = in_item.now_ms;
          maxc_next       = (in_item.max_count > apt_pkg::MAX_RESULTS) ?
                            apt_pkg::MAX_RESULTS : in_item.max_count;
          rd_idx_next     = '0;
          ev_valid_next   = 1'b0;
          matched_next    = 1'b0;
          free_found_next = 1'b0;
          count_next      = '0;
          pend_valid_next = 1'b0;
          case (in_item.opcode)
            apt_pkg::OP_UPSERT: begin
              if (in_item.peer_address[31:24] == apt_pkg::LOOPBACK_NET) begin
                out_valid_next = 1'b1;
                out_item_next  = mk_beat(apt_pkg::STS_LOOPBACK, '0, '0, 1'b1);
              end else begin
                state_next = apt_pkg::ST_SCAN;
              end
            end
            apt_pkg::OP_LIST: begin
              state_next = apt_pkg::ST_SCAN;
            end
            apt_pkg::OP_CLEAR: begin
              live_next      = '0;
              out_valid_next = 1'b1;
              out_item_next  = mk_beat(apt_pkg::STS_CLEARED, '0, '0, 1'b1);
            end
            default: begin
              // unused opcode: no effect, no beat
            end
          endcase
        end
      end

      apt_pkg::ST_SCAN: begin
        if (out_free) begin
          ev_valid_next = scan_more;
          ev_idx_next   = rd_idx[IDX_W-1:0];
          if (scan_more) begin
            rd_idx_next = CNT_W'(rd_idx + 1'b1);
          end
          if (ev_valid) begin
            if (op == apt_pkg::OP_LIST) begin
              if (ev_live) begin
                if (expired) begin
                  live_next[ev_idx] = 1'b0;
                end else if (count < maxc) begin
                  // an earlier entry is known not to be final now
                  if (pend_valid) begin
                    out_valid_next = 1'b1;
                    out_item_next  = mk_beat(apt_pkg::STS_ENTRY, pend_addr, pend_tag, 1'b0);
                  end
                  pend_valid_next = 1'b1;
                  pend_addr_next  = ent.address;
                  pend_tag_next   = ent.tag;
                  count_next      = 7'(count + 7'd1);
                end
              end
            end else begin
              if (ev_live && !matched && (ent.address == item_addr)) begin
                // refresh in place: tag and time, address unchanged
                matched_next = 1'b1;
                ram_we       = 1'b1;
                ram_waddr    = ev_idx;
              end
              if (!ev_live && !free_found) begin
                free_found_next = 1'b1;
                free_idx_next   = ev_idx;
              end
            end
          end else if (!scan_more) begin
            // every slot seen: close out the item
            state_next     = apt_pkg::ST_IDLE;
            out_valid_next = 1'b1;
            if (op == apt_pkg::OP_LIST) begin
              pend_valid_next = 1'b0;
              if (pend_valid) begin
                out_item_next = mk_beat(apt_pkg::STS_ENTRY, pend_addr, pend_tag, 1'b1);
              end else begin
                out_item_next = mk_beat(apt_pkg::STS_EMPTY, '0, '0, 1'b1);
              end
            end else if (matched) begin
              out_item_next = mk_beat(apt_pkg::STS_REFRESHED, '0, '0, 1'b1);
            end else if (free_found) begin
              ram_we                  = 1'b1;
              ram_waddr               = free_idx;
              live_next[free_idx]     = 1'b1;
              out_item_next = mk_beat(apt_pkg::STS_INSERTED, '0, '0, 1'b1);
            end else begin
              out_item_next = mk_beat(apt_pkg::STS_FULL, '0, '0, 1'b1);
            end
          end
        end
      end

      default: begin
        state_next = apt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live       <= '0;
      ttl        <= apt_pkg::TTL_RESET;
      out_valid  <= 1'b0;
      ev_valid   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      live       <= live_next;
      out_valid  <= out_valid_next;
      ev_valid   <= ev_valid_next;
      pend_valid <= pend_valid_next;
      if (cfg_write_en) begin
        ttl <= cfg_write_data;
      end
    end
  end

  // payload and scan bookkeeping, no reset needed
  always_ff @(posedge clk) begin
    out_item   <= out_item_next;
    rd_idx     <= rd_idx_next;
    ev_idx     <= ev_idx_next;
    op         <= op_next;
    item_addr  <= item_addr_next;
    item_tag   <= item_tag_next;
    item_now   <= item_now_next;
    maxc       <= maxc_next;
    matched    <= matched_next;
    free_found <= free_found_next;
    free_idx   <= free_idx_next;
    count      <= count_next;
    pend_addr  <= pend_addr_next;
    pend_tag   <= pend_tag_next;
  end

  // a listing never holds more entries than it may return
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == apt_pkg::ST_SCAN) |-> (count <= maxc))
    else $error("listing count beyond limit");

  // a held-back entry exists only during a scan
  a_pend_scan: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == apt_pkg::ST_SCAN))
    else $error("pending entry outside scan");

  // the refresh write never hits the slot being read at the same time
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != rd_idx[IDX_W-1:0]))
    else $error("ram write and read on same slot");

  // an accepted listing starts a scan
  a_list_scans: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (in_item.opcode == apt_pkg::OP_LIST)) |=> (state == apt_pkg::ST_SCAN))
    else $error("listing did not start a scan");

  // a newly inserted slot was free before
  a_insert_free: assert property (@(posedge clk) disable iff (rst)
    (out_valid_next && !(out_valid && out_stall) &&
     (out_item_next.status == apt_pkg::STS_INSERTED)) |-> !live[free_idx])
    else $error("insert into a live slot");

endmodule

FILE: rtl/core/apt_ram.sv
// generic single write port ram with registered read
module apt_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
